### rtl/lsmt_pkg.sv
// Shared types and timing constants for the LCD scanline mode timer.
// No dependencies; used by lsmt_step and lcd_scanline_mode_timer.
`timescale 1ns / 1ps

package lsmt_pkg;

  localparam int unsigned DOTS_PER_LINE   = 456;
  localparam int unsigned MODE2_LAST_DOT  = 80;
  localparam int unsigned MODE3_LAST_DOT  = 252;
  localparam int unsigned VBLANK_LINE     = 144;
  localparam int unsigned WRAP_LINE       = 154;

  localparam int unsigned DOT_W    = 9;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned STATUS_W = 7;
  localparam int unsigned DOTS_W   = 6;
  localparam int unsigned LYC_W    = 8;
  localparam int unsigned SEL_W    = 4;

  localparam logic [LINE_W-1:0] LINE_NONE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } lcd_mode_t;

  typedef struct packed {
    logic [LINE_W-1:0]   line_cnt;
    logic [DOT_W-1:0]    dot_cnt;
    logic [LINE_W-1:0]   line_reg;
    lcd_mode_t           mode;
    logic [STATUS_W-1:0] status;
    logic                frame;
  } timer_state_t;

  typedef struct packed {
    logic [SEL_W-1:0]  stat_selects;
    logic [LYC_W-1:0]  lyc_value;
    logic              display_enabled;
    logic [DOTS_W-1:0] dots_elapsed;
  } step_in_t;

  typedef struct packed {
    logic                latch_window;
    logic                draw_line;
    logic                frame_done;
    logic                vblank_request;
    logic                stat_request;
    logic [STATUS_W-1:0] status_byte;
    logic [1:0]          lcd_mode;
    logic [LINE_W-1:0]   line_number;
  } step_out_t;

endpackage

### rtl/lcd_scanline_mode_timer.sv
// Top level of the LCD scanline mode timer: stream ports, timer state, result register.
// Depends on lsmt_pkg and lsmt_step.
`timescale 1ns / 1ps
//
// Channel  Direction  Payload
// in_      slave      dots_elapsed, display_enabled, lyc_value, stat_selects
// out_     master     line_number, lcd_mode, status_byte, request and event flags
//
// One transaction per cycle in while out_ is not held; one registered result per transaction.
// The timer state updates in the cycle of acceptance; the result register holds
// the output until taken, and a new transaction is taken in the same cycle as it drains.
// Reset clears the dot counter, mode, status and frame flag; the line register reads "no line".

module lcd_scanline_mode_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] dots_elapsed, [6] display_enabled, [14:7] lyc_value, [18:15] stat_selects
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] line_number, [9:8] lcd_mode, [16:10] status_byte, [17] stat_request,
  // [18] vblank_request, [19] frame_done, [20] draw_line, [21] latch_window
  output logic [23:0] out_tdata
);

  lsmt_pkg::timer_state_t state_r;
  lsmt_pkg::timer_state_t state_nxt;
  lsmt_pkg::step_in_t     item;
  lsmt_pkg::step_out_t    result;
  logic                   out_tvalid_r;
  logic [23:0]            out_tdata_r;
  logic                   in_fire;

  assign item      = in_tdata[18:0];
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  lsmt_step u_step (
    .state_cur (state_r),
    .item      (item),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.line_cnt <= '0;
      state_r.dot_cnt  <= '0;
      state_r.line_reg <= lsmt_pkg::LINE_NONE;
      state_r.mode     <= lsmt_pkg::MODE_HBLANK;
      state_r.status   <= '0;
      state_r.frame    <= 1'b0;
      out_tvalid_r     <= 1'b0;
    end else if (in_fire) begin
      state_r      <= state_nxt;
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {2'b00, result};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/lsmt_step.sv
// Next-state and result logic for one timing update of the scanline timer.
// Depends on lsmt_pkg.
`timescale 1ns / 1ps

module lsmt_step (
  input  lsmt_pkg::timer_state_t state_cur,
  input  lsmt_pkg::step_in_t     item,
  output lsmt_pkg::timer_state_t state_nxt,
  output lsmt_pkg::step_out_t    result
);

  logic [lsmt_pkg::DOT_W:0]      dot_sum;
  logic [lsmt_pkg::DOT_W-1:0]    dot_new;
  logic [lsmt_pkg::LINE_W-1:0]   line_new;
  lsmt_pkg::lcd_mode_t           mode_new;
  logic                          line_change;
  logic                          match;
  logic [lsmt_pkg::SEL_W-1:0]    pending;
  logic                          wrap;

  always_comb begin
    dot_sum = {1'b0, state_cur.dot_cnt} + {{(lsmt_pkg::DOT_W + 1 - lsmt_pkg::DOTS_W){1'b0}},
                                           item.dots_elapsed};
    if (dot_sum >= (lsmt_pkg::DOT_W + 1)'(lsmt_pkg::DOTS_PER_LINE)) begin
      dot_new  = lsmt_pkg::DOT_W'(dot_sum - (lsmt_pkg::DOT_W + 1)'(lsmt_pkg::DOTS_PER_LINE));
      line_new = state_cur.line_cnt + 8'd1;
    end else begin
      dot_new  = dot_sum[lsmt_pkg::DOT_W-1:0];
      line_new = state_cur.line_cnt;
    end
  end

  always_comb begin
    if (line_new >= lsmt_pkg::LINE_W'(lsmt_pkg::VBLANK_LINE)) begin
      mode_new = lsmt_pkg::MODE_VBLANK;
    end else if (dot_new <= lsmt_pkg::DOT_W'(lsmt_pkg::MODE2_LAST_DOT)) begin
      mode_new = lsmt_pkg::MODE_OAM;
    end else if (dot_new <= lsmt_pkg::DOT_W'(lsmt_pkg::MODE3_LAST_DOT)) begin
      mode_new = lsmt_pkg::MODE_DRAW;
    end else begin
      mode_new = lsmt_pkg::MODE_HBLANK;
    end
  end

  assign line_change = (line_new != state_cur.line_reg);
  assign match       = (line_new == item.lyc_value);
  assign wrap        = line_change && (line_new >= lsmt_pkg::LINE_W'(lsmt_pkg::WRAP_LINE));

  always_comb begin
    pending = {match, 3'b000};
    case (mode_new)
      lsmt_pkg::MODE_HBLANK: pending[0] = 1'b1;
      lsmt_pkg::MODE_VBLANK: pending[1] = 1'b1;
      lsmt_pkg::MODE_OAM:    pending[2] = 1'b1;
      default:               pending    = {match, 3'b000};
    endcase
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    if (item.display_enabled) begin
      state_nxt.frame    = 1'b0;
      state_nxt.line_cnt = line_new;
      state_nxt.dot_cnt  = dot_new;
      state_nxt.mode     = mode_new;
      if (line_change) begin
        state_nxt.line_reg = line_new;
        state_nxt.status   = {item.stat_selects, match, mode_new};
        result.stat_request = |(pending & item.stat_selects);
        if (line_new == lsmt_pkg::LINE_W'(lsmt_pkg::VBLANK_LINE)) begin
          result.vblank_request = 1'b1;
          state_nxt.frame       = 1'b1;
        end
        if (line_new == '0) begin
          result.latch_window = 1'b1;
        end else if (wrap) begin
          state_nxt.line_cnt = '0;
          state_nxt.dot_cnt  = '0;
          state_nxt.line_reg = lsmt_pkg::LINE_NONE;
        end
      end
      result.draw_line = !wrap && (mode_new == lsmt_pkg::MODE_DRAW)
                         && (state_cur.mode != lsmt_pkg::MODE_DRAW);
    end
    result.line_number = state_nxt.line_cnt;
    result.lcd_mode    = state_nxt.mode;
    result.status_byte = state_nxt.status;
    result.frame_done  = state_nxt.frame;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for lcd_scanline_mode_timer: streams directed and random dot batches and
// checks every result against an in-bench model of the line, mode and STAT timing.
// Depends on lsmt_pkg and the lcd_scanline_mode_timer RTL.

module tb;

  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 400;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [23:0]         batch_q[$];
  lsmt_pkg::step_out_t timing_q[$];

  logic [16:0]         tm_dots = '0;
  logic [7:0]          tm_line = lsmt_pkg::LINE_NONE;
  lsmt_pkg::lcd_mode_t tm_mode = lsmt_pkg::MODE_HBLANK;
  logic [6:0]          tm_status = '0;
  logic                tm_frame = 1'b0;

  int unsigned plan_dots = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          results_seen = 0;
  int          errors = 0;
  bit          quiet = 1'b0;
  bit          held_off = 1'b0;

  lcd_scanline_mode_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL lcd_scanline_mode_timer");
    $finish;
  end

  function automatic lsmt_pkg::step_out_t timer_advance(input logic [5:0] dots,
                                                        input logic en,
                                                        input logic [7:0] lyc,
                                                        input logic [3:0] sel);
    lsmt_pkg::step_out_t r;
    int unsigned         line;
    int unsigned         dot;
    lsmt_pkg::lcd_mode_t prev;
    logic                match;
    logic [3:0]          pend;
    logic                wrapped;
    r = '0;
    wrapped = 1'b0;
    if (en) begin
      tm_frame = 1'b0;
      tm_dots = tm_dots + 17'(dots);
      line = tm_dots / lsmt_pkg::DOTS_PER_LINE;
      dot = tm_dots % lsmt_pkg::DOTS_PER_LINE;
      prev = tm_mode;
      if (line >= lsmt_pkg::VBLANK_LINE) begin
        tm_mode = lsmt_pkg::MODE_VBLANK;
      end else if (dot <= lsmt_pkg::MODE2_LAST_DOT) begin
        tm_mode = lsmt_pkg::MODE_OAM;
      end else if (dot <= lsmt_pkg::MODE3_LAST_DOT) begin
        tm_mode = lsmt_pkg::MODE_DRAW;
      end else begin
        tm_mode = lsmt_pkg::MODE_HBLANK;
      end
      if (8'(line) != tm_line) begin
        match = (8'(line) == lyc);
        tm_line = 8'(line);
        tm_status = {sel, match, tm_mode};
        // drawing mode has no STAT source
        pend = {match, 3'b000} | ((4'b0001 << tm_mode) & 4'b0111);
        r.stat_request = |(pend & sel);
        if (line == lsmt_pkg::VBLANK_LINE) begin
          r.vblank_request = 1'b1;
          tm_frame = 1'b1;
        end
        if (line == 0) begin
          r.latch_window = 1'b1;
        end else if (line >= lsmt_pkg::WRAP_LINE) begin
          tm_dots = '0;
          tm_line = lsmt_pkg::LINE_NONE;
          wrapped = 1'b1;
        end
      end
      r.draw_line = !wrapped && tm_mode != prev && tm_line < lsmt_pkg::VBLANK_LINE &&
                    tm_mode == lsmt_pkg::MODE_DRAW;
    end
    r.line_number = 8'(tm_dots / lsmt_pkg::DOTS_PER_LINE);
    r.lcd_mode = tm_mode;
    r.status_byte = tm_status;
    r.frame_done = tm_frame;
    return r;
  endfunction

  task automatic plan_batch(input logic [5:0] dots, input logic en, input logic [7:0] lyc,
                            input logic [3:0] sel);
    batch_q.push_back({5'b0, sel, lyc, en, dots});
    if (en) begin
      plan_dots += dots;
      if (plan_dots / lsmt_pkg::DOTS_PER_LINE >= lsmt_pkg::WRAP_LINE) plan_dots = 0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_timing(input lsmt_pkg::step_out_t want,
                              input lsmt_pkg::step_out_t got);
    check_field("line_number", want.line_number, got.line_number);
    check_field("lcd_mode", want.lcd_mode, got.lcd_mode);
    check_field("status_byte", want.status_byte, got.status_byte);
    check_field("stat_request", want.stat_request, got.stat_request);
    check_field("vblank_request", want.vblank_request, got.vblank_request);
    check_field("frame_done", want.frame_done, got.frame_done);
    check_field("draw_line", want.draw_line, got.draw_line);
    check_field("latch_window", want.latch_window, got.latch_window);
  endtask

  initial begin
    int unsigned dots;
    int unsigned pick;
    logic [7:0]  lyc;
    logic        en;
    plan_batch(6'd63, 1'b0, 8'd255, 4'hF);
    plan_batch(6'd0, 1'b1, 8'd0, 4'hF);
    plan_batch(6'd63, 1'b1, 8'd255, 4'h0);
    plan_batch(6'd18, 1'b1, 8'd0, 4'h0);
    plan_batch(6'd63, 1'b1, 8'd0, 4'h5);
    plan_batch(6'd63, 1'b1, 8'd0, 4'hA);
    plan_batch(6'd45, 1'b1, 8'd0, 4'hF);
    plan_batch(6'd1, 1'b1, 8'd0, 4'hF);
    plan_batch(6'd63, 1'b0, 8'd1, 4'hF);
    plan_batch(6'd63, 1'b1, 8'd1, 4'h8);
    plan_batch(6'd63, 1'b1, 8'd1, 4'h8);
    plan_batch(6'd63, 1'b1, 8'd1, 4'h8);
    plan_batch(6'd14, 1'b1, 8'd1, 4'h8);
    plan_batch(6'd0, 1'b1, 8'd255, 4'h0);
    plan_batch(6'd0, 1'b0, 8'd0, 4'h0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) dots = 0;
      else if (pick < 3) dots = $urandom_range(0, 63);
      else dots = $urandom_range(56, 63);
      en = ($urandom_range(0, 11) != 0);
      // aim the compare value at the line this batch lands on half the time
      if ($urandom_range(0, 1) != 0) lyc = 8'((plan_dots + dots) / lsmt_pkg::DOTS_PER_LINE);
      else lyc = 8'($urandom_range(0, 255));
      plan_batch(6'(dots), en, lyc, 4'($urandom_range(0, 15)));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (batch_q.size() != 0 || in_tvalid || timing_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS lcd_scanline_mode_timer");
    end else begin
      $display("FAIL lcd_scanline_mode_timer");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        timing_q.push_back(timer_advance(in_tdata[5:0], in_tdata[6], in_tdata[14:7],
                                         in_tdata[18:15]));
      end
      quiet <= (batch_q.size() < QUIET_TAIL);
      if (!in_tvalid || in_tready) begin
        if (gap_left == 0 && !quiet && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 11);
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (batch_q.size() != 0) begin
          in_tdata <= batch_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (timing_q.size() == 0) begin
          errors++;
          $display("%0t: expected no transaction, actual %h", $time, out_tdata);
        end else begin
          check_timing(timing_q.pop_front(), lsmt_pkg::step_out_t'(out_tdata[21:0]));
        end
      end
      // hold off long enough for the block to back up its input
      if (results_seen == HOLD_AT && !held_off) begin
        held_off = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule

### filelist.f
rtl/lsmt_pkg.sv
rtl/lsmt_step.sv
rtl/lcd_scanline_mode_timer.sv
tb/tb.sv
